// ----- rtl/ucl_pkg.sv -----
`default_nettype none

package ucl_pkg;

    // operation codes carried on s_axis_tuser
    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_INSERT    = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;
    localparam logic [1:0] OP_READ_NEXT = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_MIN_X   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_INV_X   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_INV_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CELLS_X = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_CELLS_Y = 3'd5;

    // field widths
    localparam int unsigned POS_W    = 32;
    localparam int unsigned REF_W    = 12;
    localparam int unsigned CELLS_W  = 7;
    localparam int unsigned LINK_W   = REF_W + 1;   // valid flag above particle
    localparam int unsigned CENTRY_W = REF_W + 1;   // occupied flag above head
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 16;

    // 3x3 neighborhood offsets, walked from the last entry down to the first
    localparam int unsigned NUM_NB = 9;
    localparam logic [3:0]  NB_LAST = 4'd8;
    localparam logic [1:0] NB_DX [0:NUM_NB-1] = '{
        2'b11, 2'b00, 2'b01, 2'b11, 2'b00, 2'b01, 2'b11, 2'b00, 2'b01
    };
    localparam logic [1:0] NB_DY [0:NUM_NB-1] = '{
        2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01
    };

    typedef struct packed {
        logic [POS_W-1:0] min_x;
        logic [POS_W-1:0] min_y;
        logic [POS_W-1:0] inv_x;
        logic [POS_W-1:0] inv_y;
    } t_axis_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_INS_WR,
        ST_Q_ADDR,
        ST_Q_DATA,
        ST_Q_END,
        ST_LINK_RD,
        ST_LINK_OUT
    } t_state;

    typedef enum logic [2:0] {
        BIN_IDLE,
        BIN_SUB,
        BIN_MUL,
        BIN_CLAMP,
        BIN_DONE
    } t_bin_state;

endpackage

`default_nettype wire

// ----- rtl/ucl_ram.sv -----
`default_nettype none

module ucl_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ucl_bin.sv -----
`default_nettype none

// position to cell index, x axis then y axis through one shared multiplier
module ucl_bin #(
    parameter int unsigned CXW = 6,
    parameter int unsigned CYW = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire ucl_pkg::t_axis_cfg        i_cfg,
    input  wire logic [ucl_pkg::POS_W-1:0] i_pos_x,
    input  wire logic [ucl_pkg::POS_W-1:0] i_pos_y,
    input  wire logic [CXW-1:0]            i_last_x,
    input  wire logic [CYW-1:0]            i_last_y,
    output logic                           o_done,
    output logic [CXW-1:0]                 o_cell_x,
    output logic [CYW-1:0]                 o_cell_y
);

    ucl_pkg::t_bin_state r_state;
    ucl_pkg::t_bin_state n_state;

    logic                        r_axis;
    logic [ucl_pkg::POS_W:0]     r_d;
    logic [2*ucl_pkg::POS_W-1:0] r_prod;
    logic                        r_nonpos;
    logic [CXW-1:0]              r_cell_x;
    logic [CYW-1:0]              r_cell_y;

    logic [ucl_pkg::POS_W-1:0]   w_pos;
    logic [ucl_pkg::POS_W-1:0]   w_min;
    logic [ucl_pkg::POS_W-1:0]   w_inv;
    logic [ucl_pkg::POS_W-1:0]   w_idx;
    logic [CXW-1:0]              w_cx;
    logic [CYW-1:0]              w_cy;

    assign w_pos = r_axis ? i_pos_y : i_pos_x;
    assign w_min = r_axis ? i_cfg.min_y : i_cfg.min_x;
    assign w_inv = r_axis ? i_cfg.inv_y : i_cfg.inv_x;
    assign w_idx = r_prod[2*ucl_pkg::POS_W-1:ucl_pkg::POS_W];

    // clamp to the last column / row in use; non-positive offsets bin to 0
    always_comb begin
        if (r_nonpos) begin
            w_cx = '0;
        end else if (w_idx > ucl_pkg::POS_W'(i_last_x)) begin
            w_cx = i_last_x;
        end else begin
            w_cx = CXW'(w_idx);
        end
        if (r_nonpos) begin
            w_cy = '0;
        end else if (w_idx > ucl_pkg::POS_W'(i_last_y)) begin
            w_cy = i_last_y;
        end else begin
            w_cy = CYW'(w_idx);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ucl_pkg::BIN_IDLE:  if (i_start) n_state = ucl_pkg::BIN_SUB;
            ucl_pkg::BIN_SUB:   n_state = ucl_pkg::BIN_MUL;
            ucl_pkg::BIN_MUL:   n_state = ucl_pkg::BIN_CLAMP;
            ucl_pkg::BIN_CLAMP: n_state = r_axis ? ucl_pkg::BIN_DONE : ucl_pkg::BIN_SUB;
            ucl_pkg::BIN_DONE:  n_state = ucl_pkg::BIN_IDLE;
            default:            n_state = ucl_pkg::BIN_IDLE;
        endcase
    end

    always_comb begin
        o_done   = (r_state == ucl_pkg::BIN_DONE);
        o_cell_x = r_cell_x;
        o_cell_y = r_cell_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucl_pkg::BIN_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ucl_pkg::BIN_IDLE) begin
                r_axis <= 1'b0;
            end else if (r_state == ucl_pkg::BIN_CLAMP) begin
                r_axis <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ucl_pkg::BIN_SUB) begin
            r_d <= {w_pos[ucl_pkg::POS_W-1], w_pos} - {w_min[ucl_pkg::POS_W-1], w_min};
        end
        if (r_state == ucl_pkg::BIN_MUL) begin
            r_prod   <= (2*ucl_pkg::POS_W)'(r_d[ucl_pkg::POS_W-1:0])
                        * (2*ucl_pkg::POS_W)'(w_inv);
            r_nonpos <= r_d[ucl_pkg::POS_W] || (r_d == '0);
        end
        if (r_state == ucl_pkg::BIN_CLAMP) begin
            if (r_axis) begin
                r_cell_y <= w_cy;
            end else begin
                r_cell_x <= w_cx;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/uniform_grid_cell_list.sv -----
`default_nettype none

// Two-dimensional cell-list binning engine. Requests arrive on the s_axis side with the
// operation on s_axis_tuser (clear, insert, neighbor query, read next link); results
// leave on the m_axis side with the particle reference in m_axis_tdata, its valid flag
// on m_axis_tuser and the final result of a request marked by m_axis_tlast. A position
// is binned per axis as floor((pos - domain_min) * inv_cell / 2^32), zero for offsets
// at or below the edge, clamped to the columns and rows in use; one 32x32 multiplier
// does x then y. One request is handled at a time: an insert bins its position, reads
// the home cell from the cell table and writes the cell and the link; a read-next reads
// the link table and then waits on the output if need be; a query is taken and binned,
// then each neighbor cell inside the grid is read, one at a time through the single
// read port of the cell table, and each cell outside it is skipped, before a final
// result, with any wait on the output. A clear, and reset as well, sweeps the cell
// table one entry a cycle, all MAX_CELLS_X*MAX_CELLS_Y entries (4096 by default),
// during which no request is taken; configuration writes are taken at any time but are
// meant to be done only while the block is idle. A finished result sits in an output
// register, so the block takes the next request while it waits.
module uniform_grid_cell_list #(
    parameter int unsigned MAX_CELLS_X   = 64,
    parameter int unsigned MAX_CELLS_Y   = 64,
    parameter int unsigned MAX_PARTICLES = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [ucl_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [ucl_pkg::CFG_DW-1:0]   i_cfg_wdata,
    // request stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [ucl_pkg::S_DATA_W-1:0] s_axis_tdata,  // particle_id, pos_x, pos_y, pad
    input  wire logic [1:0]                   s_axis_tuser,  // operation
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [ucl_pkg::M_DATA_W-1:0]      m_axis_tdata,  // particle_ref, pad
    output logic                              m_axis_tuser,  // ref_valid
    output logic                              m_axis_tlast   // last_result
);

    localparam int unsigned CXW       = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
    localparam int unsigned CYW       = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
    localparam int unsigned NUM_CELLS = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int unsigned CAW       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int unsigned PAW       = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int unsigned RW        = ucl_pkg::REF_W;
    localparam int unsigned PW        = ucl_pkg::POS_W;

    // configuration registers
    logic [PW-1:0]               r_min_x;
    logic [PW-1:0]               r_min_y;
    logic [PW-1:0]               r_inv_x;
    logic [PW-1:0]               r_inv_y;
    logic [ucl_pkg::CELLS_W-1:0] r_cells_x;
    logic [ucl_pkg::CELLS_W-1:0] r_cells_y;

    // sequencer
    ucl_pkg::t_state r_state;
    ucl_pkg::t_state n_state;
    logic [CAW-1:0]  r_sweep;
    logic [3:0]      r_k;
    logic            r_have;
    logic [RW-1:0]   r_pend;

    // request held for the duration of its work
    logic [1:0]      r_op;
    logic [RW-1:0]   r_pid;
    logic            r_pid_ok;
    logic [PW-1:0]   r_pos_x;
    logic [PW-1:0]   r_pos_y;

    // output register
    logic            r_out_valid;
    logic [RW-1:0]   r_out_ref;
    logic            r_out_rv;
    logic            r_out_last;

    // request fields
    logic [1:0]      w_in_op;
    logic [RW-1:0]   w_in_pid;
    logic [PW-1:0]   w_in_pos_x;
    logic [PW-1:0]   w_in_pos_y;
    logic            w_accept;
    logic            w_in_pid_ok;

    // grid size in use
    logic [31:0]     w_eff_x;
    logic [31:0]     w_eff_y;
    logic [CXW-1:0]  w_last_x;
    logic [CYW-1:0]  w_last_y;

    // binning unit
    ucl_pkg::t_axis_cfg w_axis_cfg;
    logic            w_bin_start;
    logic            w_bin_done;
    logic [CXW-1:0]  w_cell_x;
    logic [CYW-1:0]  w_cell_y;
    logic [CAW-1:0]  w_home_addr;

    // neighbor walk
    logic [1:0]          w_dx;
    logic [1:0]          w_dy;
    logic signed [CXW+1:0] w_nx;
    logic signed [CYW+1:0] w_ny;
    logic                w_nb_in;
    logic [CAW-1:0]      w_nb_addr;

    // memories
    logic                          w_cell_we;
    logic [CAW-1:0]                w_cell_waddr;
    logic [ucl_pkg::CENTRY_W-1:0]  w_cell_wdata;
    logic                          w_cell_re;
    logic [CAW-1:0]                w_cell_raddr;
    logic [ucl_pkg::CENTRY_W-1:0]  w_cell_q;
    logic                          w_link_we;
    logic [ucl_pkg::LINK_W-1:0]    w_link_wdata;
    logic                          w_link_re;
    logic [ucl_pkg::LINK_W-1:0]    w_link_q;
    logic                          w_link_ok;

    // result push
    logic            w_slot_free;
    logic            w_push;
    logic [RW-1:0]   w_push_ref;
    logic            w_push_rv;
    logic            w_push_last;
    logic            w_q_stall;

    // request unpacking
    assign w_in_op     = s_axis_tuser;
    assign w_in_pid    = s_axis_tdata[RW-1:0];
    assign w_in_pos_x  = s_axis_tdata[RW+PW-1:RW];
    assign w_in_pos_y  = s_axis_tdata[RW+2*PW-1:RW+PW];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_in_pid_ok = (32'(w_in_pid) < 32'(MAX_PARTICLES));

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_inv_x   <= 32'd65536;
            r_inv_y   <= 32'd65536;
            r_cells_x <= 7'd64;
            r_cells_y <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ucl_pkg::CFG_MIN_X:   r_min_x   <= i_cfg_wdata;
                ucl_pkg::CFG_MIN_Y:   r_min_y   <= i_cfg_wdata;
                ucl_pkg::CFG_INV_X:   r_inv_x   <= i_cfg_wdata;
                ucl_pkg::CFG_INV_Y:   r_inv_y   <= i_cfg_wdata;
                ucl_pkg::CFG_CELLS_X: r_cells_x <= i_cfg_wdata[ucl_pkg::CELLS_W-1:0];
                ucl_pkg::CFG_CELLS_Y: r_cells_y <= i_cfg_wdata[ucl_pkg::CELLS_W-1:0];
                default: ;
            endcase
        end
    end

    // zero columns or rows act as one, more than the maximum act as the maximum
    always_comb begin
        w_eff_x = (r_cells_x == '0) ? 32'd1 : 32'(r_cells_x);
        if (w_eff_x > 32'(MAX_CELLS_X)) begin
            w_eff_x = 32'(MAX_CELLS_X);
        end
        w_eff_y = (r_cells_y == '0) ? 32'd1 : 32'(r_cells_y);
        if (w_eff_y > 32'(MAX_CELLS_Y)) begin
            w_eff_y = 32'(MAX_CELLS_Y);
        end
        w_last_x = CXW'(w_eff_x - 32'd1);
        w_last_y = CYW'(w_eff_y - 32'd1);
    end

    assign w_axis_cfg.min_x = r_min_x;
    assign w_axis_cfg.min_y = r_min_y;
    assign w_axis_cfg.inv_x = r_inv_x;
    assign w_axis_cfg.inv_y = r_inv_y;

    ucl_bin #(
        .CXW (CXW),
        .CYW (CYW)
    ) u_bin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_bin_start),
        .i_cfg    (w_axis_cfg),
        .i_pos_x  (r_pos_x),
        .i_pos_y  (r_pos_y),
        .i_last_x (w_last_x),
        .i_last_y (w_last_y),
        .o_done   (w_bin_done),
        .o_cell_x (w_cell_x),
        .o_cell_y (w_cell_y)
    );

    assign w_home_addr = CAW'(32'(w_cell_y) * 32'(MAX_CELLS_X) + 32'(w_cell_x));

    // neighbor cell for the current offset index, with a grid bounds check
    assign w_dx = ucl_pkg::NB_DX[r_k];
    assign w_dy = ucl_pkg::NB_DY[r_k];
    assign w_nx = $signed({2'b00, w_cell_x}) + $signed({{CXW{w_dx[1]}}, w_dx});
    assign w_ny = $signed({2'b00, w_cell_y}) + $signed({{CYW{w_dy[1]}}, w_dy});
    assign w_nb_in = !w_nx[CXW+1] && (w_nx[CXW:0] <= {1'b0, w_last_x})
                  && !w_ny[CYW+1] && (w_ny[CYW:0] <= {1'b0, w_last_y});
    assign w_nb_addr = CAW'(32'(w_ny[CYW:0]) * 32'(MAX_CELLS_X) + 32'(w_nx[CXW:0]));

    // cell table: occupied flag above the list head
    ucl_ram #(
        .WIDTH (ucl_pkg::CENTRY_W),
        .DEPTH (NUM_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_re    (w_cell_re),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_q)
    );

    // next link table: valid flag above the particle
    ucl_ram #(
        .WIDTH (ucl_pkg::LINK_W),
        .DEPTH (MAX_PARTICLES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (PAW'(r_pid)),
        .i_wdata (w_link_wdata),
        .i_re    (w_link_re),
        .i_raddr (PAW'(r_pid)),
        .o_rdata (w_link_q)
    );

    assign w_slot_free = !r_out_valid || m_axis_tready;
    // a found head waits until the previous one has left, since only the last one is marked
    assign w_q_stall   = w_cell_q[RW] && r_have && !w_slot_free;
    assign w_link_ok   = r_pid_ok && w_link_q[RW];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ucl_pkg::ST_CLEAR: begin
                if (r_sweep == CAW'(NUM_CELLS - 1)) n_state = ucl_pkg::ST_IDLE;
            end
            ucl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_op)
                        ucl_pkg::OP_CLEAR:     n_state = ucl_pkg::ST_CLEAR;
                        ucl_pkg::OP_INSERT:    n_state = w_in_pid_ok ? ucl_pkg::ST_BIN
                                                                     : ucl_pkg::ST_IDLE;
                        ucl_pkg::OP_QUERY:     n_state = ucl_pkg::ST_BIN;
                        ucl_pkg::OP_READ_NEXT: n_state = ucl_pkg::ST_LINK_RD;
                        default:               n_state = ucl_pkg::ST_IDLE;
                    endcase
                end
            end
            ucl_pkg::ST_BIN: begin
                if (w_bin_done) begin
                    n_state = (r_op == ucl_pkg::OP_INSERT) ? ucl_pkg::ST_INS_WR
                                                           : ucl_pkg::ST_Q_ADDR;
                end
            end
            ucl_pkg::ST_INS_WR: n_state = ucl_pkg::ST_IDLE;
            ucl_pkg::ST_Q_ADDR: begin
                if (w_nb_in) begin
                    n_state = ucl_pkg::ST_Q_DATA;
                end else if (r_k == '0) begin
                    n_state = ucl_pkg::ST_Q_END;
                end
            end
            ucl_pkg::ST_Q_DATA: begin
                if (!w_q_stall) begin
                    n_state = (r_k == '0) ? ucl_pkg::ST_Q_END : ucl_pkg::ST_Q_ADDR;
                end
            end
            ucl_pkg::ST_Q_END: begin
                if (w_slot_free) n_state = ucl_pkg::ST_IDLE;
            end
            ucl_pkg::ST_LINK_RD: n_state = ucl_pkg::ST_LINK_OUT;
            ucl_pkg::ST_LINK_OUT: begin
                if (w_slot_free) n_state = ucl_pkg::ST_IDLE;
            end
            default: n_state = ucl_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_bin_start   = 1'b0;
        w_cell_we     = 1'b0;
        w_cell_waddr  = r_sweep;
        w_cell_wdata  = '0;
        w_cell_re     = 1'b0;
        w_cell_raddr  = w_nb_addr;
        w_link_we     = 1'b0;
        w_link_wdata  = '0;
        w_link_re     = 1'b0;
        w_push        = 1'b0;
        w_push_ref    = r_pend;
        w_push_rv     = 1'b1;
        w_push_last   = 1'b0;
        unique case (r_state)
            ucl_pkg::ST_CLEAR: begin
                w_cell_we = 1'b1;
            end
            ucl_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_bin_start   = w_accept && (((w_in_op == ucl_pkg::OP_INSERT) && w_in_pid_ok)
                                             || (w_in_op == ucl_pkg::OP_QUERY));
            end
            ucl_pkg::ST_BIN: begin
                // insert reads its home cell as soon as the index is known
                w_cell_re    = w_bin_done && (r_op == ucl_pkg::OP_INSERT);
                w_cell_raddr = w_home_addr;
            end
            ucl_pkg::ST_INS_WR: begin
                w_cell_we    = 1'b1;
                w_cell_waddr = w_home_addr;
                w_cell_wdata = {1'b1, r_pid};
                w_link_we    = 1'b1;
                w_link_wdata = w_cell_q[RW] ? {1'b1, w_cell_q[RW-1:0]} : '0;
            end
            ucl_pkg::ST_Q_ADDR: begin
                w_cell_re = w_nb_in;
            end
            ucl_pkg::ST_Q_DATA: begin
                w_push = w_cell_q[RW] && r_have && w_slot_free;
            end
            ucl_pkg::ST_Q_END: begin
                // no occupied neighbor gives one empty result
                w_push      = w_slot_free;
                w_push_ref  = r_have ? r_pend : '0;
                w_push_rv   = r_have;
                w_push_last = 1'b1;
            end
            ucl_pkg::ST_LINK_RD: begin
                w_link_re = r_pid_ok;
            end
            ucl_pkg::ST_LINK_OUT: begin
                w_push      = w_slot_free;
                w_push_ref  = w_link_ok ? w_link_q[RW-1:0] : '0;
                w_push_rv   = w_link_ok;
                w_push_last = 1'b1;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ucl_pkg::ST_CLEAR;
            r_sweep     <= '0;
            r_k         <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ucl_pkg::ST_CLEAR) begin
                r_sweep <= r_sweep + CAW'(1);
            end else if (w_accept) begin
                r_sweep <= '0;
            end

            if ((r_state == ucl_pkg::ST_BIN) && w_bin_done) begin
                r_k <= ucl_pkg::NB_LAST;
            end else if ((r_state == ucl_pkg::ST_Q_ADDR) && !w_nb_in && (r_k != '0)) begin
                r_k <= r_k - 4'd1;
            end else if ((r_state == ucl_pkg::ST_Q_DATA) && !w_q_stall && (r_k != '0)) begin
                r_k <= r_k - 4'd1;
            end

            if (r_state == ucl_pkg::ST_IDLE) begin
                r_have <= 1'b0;
            end else if ((r_state == ucl_pkg::ST_Q_DATA) && !w_q_stall && w_cell_q[RW]) begin
                r_have <= 1'b1;
            end

            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_in_op;
            r_pid    <= w_in_pid;
            r_pid_ok <= w_in_pid_ok;
            r_pos_x  <= w_in_pos_x;
            r_pos_y  <= w_in_pos_y;
        end
        if ((r_state == ucl_pkg::ST_Q_DATA) && !w_q_stall && w_cell_q[RW]) begin
            r_pend <= w_cell_q[RW-1:0];
        end
        if (w_push) begin
            r_out_ref  <= w_push_ref;
            r_out_rv   <= w_push_rv;
            r_out_last <= w_push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ucl_pkg::M_DATA_W - RW){1'b0}}, r_out_ref};
    assign m_axis_tuser  = r_out_rv;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/ucl_checker.sv -----
`default_nettype none

module ucl_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [ucl_pkg::S_DATA_W-1:0] s_axis_tdata,
    input wire logic [1:0]                   s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [ucl_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic                         m_axis_tuser,
    input wire logic                         m_axis_tlast
);

    // reset starts the table sweep with nothing in the output register
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request taken or result shown right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // an empty reference is always a lone final result with zero data
    a_empty_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty reference not final or not zero");

    // the block takes no request in the cycle after a read-next is taken
    a_link_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ucl_pkg::OP_READ_NEXT)
            |=> !s_axis_tready)
        else $error("request taken while a read-next is in work");

endmodule

bind uniform_grid_cell_list ucl_checker u_ucl_checker (.*);

`default_nettype wire
